// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
// bba_pkg: types, constants and elaboration helpers for the buddy block allocator
// depends on nothing; used by the top level and bba_map_store by scoped names

package bba_pkg;

    localparam int ORDER_W  = 4;
    localparam int COUNT_W  = 11;
    localparam int ROW_LG   = 6;
    localparam int ROW_BITS = 1 << ROW_LG;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CNT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // map rows that hold the blocks of one order
    function automatic int rows_at(int top_ord, int o);
        if (top_ord - o >= ROW_LG) begin
            return 1 << (top_ord - o - ROW_LG);
        end
        return 1;
    endfunction

    // first map row of one order
    function automatic int row_base(int top_ord, int o);
        int b;
        b = 0;
        for (int i = 0; i < o; i++) begin
            b += rows_at(top_ord, i);
        end
        return b;
    endfunction

    // index of the lowest set bit of a map row
    function automatic logic [ROW_LG-1:0] lowest_bit(logic [ROW_BITS-1:0] w);
        logic [ROW_BITS-1:0] iso;
        logic [ROW_LG-1:0]   idx;
        iso = w & (~w + ROW_BITS'(1));
        idx = '0;
        for (int i = 0; i < ROW_BITS; i++) begin
            if (iso[i]) begin
                idx = idx | ROW_LG'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// buddy_block_allocator: top level, sequencer, free counts and result register
// depends on bba_pkg and bba_map_store
//
// usage:
//   s_ channel takes one request word: s_mode 0 allocates a block of 2^s_order
//   units, s_mode 1 frees the block at s_block_address of that order.
//   m_ channel returns one word per request: m_granted_address and m_status
//   (1 = out of memory on allocate).
//   the free bitmap lives in a 64-bit wide row store; one read-modify-write
//   unit and one count adder are stepped by the sequencer, so a request is
//   worked in steps and s_ready is low meanwhile.
//   allocate steps: decode, a count check per order, a read and a check per row
//   scanned, a read and a write per split level; free: decode, then a read and a
//   check per merge level; an order above the top goes straight to the result.
//   the result sits in an output register; the next request is taken while
//   it waits, and a stalled m_ready holds the word and then the sequencer.
//   after reset only the single top-order block is free; no clearing pass.

module buddy_block_allocator #(
    parameter int MAX_ORDER = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [bba_pkg::ORDER_W-1:0]  s_order,
    input  logic [MAX_ORDER-1:0]         s_block_address,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [MAX_ORDER-1:0]         m_granted_address,
    output logic                         m_status
);

    localparam int ORDERS   = MAX_ORDER + 1;
    localparam int OW       = $clog2(MAX_ORDER + 2);
    localparam int CIW      = $clog2(ORDERS);
    localparam int TOT_ROWS = bba_pkg::row_base(MAX_ORDER, ORDERS);
    localparam int RAW      = $clog2(TOT_ROWS);
    localparam int TOP_ROW  = bba_pkg::row_base(MAX_ORDER, MAX_ORDER);
    localparam int SXW      = MAX_ORDER + bba_pkg::ROW_LG;
    localparam int RB       = bba_pkg::ROW_BITS;
    localparam int RL       = bba_pkg::ROW_LG;

    logic [RAW-1:0] base_lut [ORDERS];
    logic [RAW-1:0] rows_lut [ORDERS];

    for (genvar g = 0; g < ORDERS; g++) begin : g_lut
        assign base_lut[g] = RAW'(bba_pkg::row_base(MAX_ORDER, g));
        assign rows_lut[g] = RAW'(bba_pkg::rows_at(MAX_ORDER, g));
    end

    bba_pkg::state_t              state_reg, state_next;
    logic                         mode_reg, mode_next;
    logic [bba_pkg::ORDER_W-1:0]  ord_reg, ord_next;
    logic [MAX_ORDER-1:0]         addr_reg, addr_next;
    logic [OW-1:0]                o_reg, o_next;
    logic [MAX_ORDER-1:0]         seg_reg, seg_next;
    logic [RAW-1:0]               k_reg, k_next;
    logic                         fail_reg, fail_next;
    logic [bba_pkg::COUNT_W-1:0]  cnt_reg [ORDERS];
    logic                         m_valid_reg, m_valid_next;
    logic [MAX_ORDER-1:0]         m_addr_reg, m_addr_next;
    logic                         m_status_reg, m_status_next;

    logic [CIW-1:0]               cidx, cidx_dn;
    logic [OW-1:0]                o_dn;
    logic [MAX_ORDER-1:0]         seg_dn;
    logic [SXW-1:0]               segx_cur, segx_dn, seg_fx;
    logic [RAW-1:0]               cur_row, dn_row, scan_row;
    logic [RL-1:0]                lo_cur;
    logic [RL-1:0]                ffs_idx;
    logic [MAX_ORDER-1:0]         seg_found;
    logic                         order_bad;
    logic                         out_free;
    logic                         buddy_free;

    logic [RAW-1:0]               rd_addr;
    logic [RB-1:0]                rd_data;
    logic                         wr_en;
    logic [RB-1:0]                wr_data;
    bba_pkg::cnt_op_t             cnt_op;

    assign cidx      = o_reg[CIW-1:0];
    assign o_dn      = o_reg - OW'(1);
    assign cidx_dn   = o_dn[CIW-1:0];
    assign seg_dn    = seg_reg << 1;
    assign segx_cur  = SXW'(seg_reg);
    assign segx_dn   = SXW'(seg_dn);
    assign lo_cur    = segx_cur[RL-1:0];
    assign cur_row   = base_lut[cidx] + RAW'(segx_cur >> RL);
    assign dn_row    = base_lut[cidx_dn] + RAW'(segx_dn >> RL);
    assign scan_row  = base_lut[cidx] + k_reg;
    assign ffs_idx   = bba_pkg::lowest_bit(rd_data);
    assign seg_fx    = (SXW'(k_reg) << RL) | SXW'(ffs_idx);
    assign seg_found = seg_fx[MAX_ORDER-1:0];
    assign order_bad = (int'(ord_reg) > MAX_ORDER);
    assign out_free  = !m_valid_reg || m_ready;
    assign buddy_free = (int'(o_reg) < MAX_ORDER) && rd_data[lo_cur ^ RL'(1)];

    bba_map_store #(
        .ROWS    (TOT_ROWS),
        .RAW     (RAW),
        .TOP_ROW (TOP_ROW)
    ) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr ((state_reg == bba_pkg::ST_SCAN_CHK) ? scan_row : cur_row),
        .wr_data (wr_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = bba_pkg::ST_DECODE;
                end
            end
            bba_pkg::ST_DECODE: begin
                if (order_bad) begin
                    state_next = bba_pkg::ST_DONE;
                end else if (mode_reg) begin
                    state_next = bba_pkg::ST_FREE_RD;
                end else begin
                    state_next = bba_pkg::ST_CNT;
                end
            end
            bba_pkg::ST_CNT: begin
                if (int'(o_reg) > MAX_ORDER) begin
                    state_next = bba_pkg::ST_DONE;
                end else if (cnt_reg[cidx] != '0) begin
                    state_next = bba_pkg::ST_SCAN_RD;
                end
            end
            bba_pkg::ST_SCAN_RD: state_next = bba_pkg::ST_SCAN_CHK;
            bba_pkg::ST_SCAN_CHK: begin
                if (rd_data != '0) begin
                    state_next = (o_reg > OW'(ord_reg)) ? bba_pkg::ST_SPLIT_RD
                                                        : bba_pkg::ST_DONE;
                end else if (k_reg + RAW'(1) == rows_lut[cidx]) begin
                    state_next = bba_pkg::ST_DONE;
                end else begin
                    state_next = bba_pkg::ST_SCAN_RD;
                end
            end
            bba_pkg::ST_SPLIT_RD: state_next = bba_pkg::ST_SPLIT_WR;
            bba_pkg::ST_SPLIT_WR: begin
                state_next = (o_reg > OW'(ord_reg)) ? bba_pkg::ST_SPLIT_RD
                                                    : bba_pkg::ST_DONE;
            end
            bba_pkg::ST_FREE_RD: state_next = bba_pkg::ST_FREE_CHK;
            bba_pkg::ST_FREE_CHK: begin
                state_next = buddy_free ? bba_pkg::ST_FREE_RD : bba_pkg::ST_DONE;
            end
            bba_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            default: state_next = bba_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        mode_next     = mode_reg;
        ord_next      = ord_reg;
        addr_next     = addr_reg;
        o_next        = o_reg;
        seg_next      = seg_reg;
        k_next        = k_reg;
        fail_next     = fail_reg;
        m_valid_next  = m_valid_reg;
        m_addr_next   = m_addr_reg;
        m_status_next = m_status_reg;
        rd_addr       = cur_row;
        wr_en         = 1'b0;
        wr_data       = rd_data;
        cnt_op        = bba_pkg::CNT_HOLD;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            bba_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mode_next = s_mode;
                    ord_next  = s_order;
                    addr_next = s_block_address;
                    fail_next = 1'b0;
                end
            end
            bba_pkg::ST_DECODE: begin
                o_next   = OW'(ord_reg);
                seg_next = addr_reg >> ord_reg;
                k_next   = '0;
                fail_next = order_bad && !mode_reg;
            end
            bba_pkg::ST_CNT: begin
                if (int'(o_reg) > MAX_ORDER) begin
                    fail_next = 1'b1;
                end else if (cnt_reg[cidx] == '0) begin
                    o_next = o_reg + OW'(1);
                end
            end
            bba_pkg::ST_SCAN_RD: begin
                rd_addr = scan_row;
            end
            bba_pkg::ST_SCAN_CHK: begin
                if (rd_data != '0) begin
                    seg_next = seg_found;
                    wr_en    = 1'b1;
                    wr_data  = rd_data & ~(RB'(1) << ffs_idx);
                    cnt_op   = bba_pkg::CNT_DEC;
                end else if (k_reg + RAW'(1) == rows_lut[cidx]) begin
                    fail_next = 1'b1;
                end else begin
                    k_next = k_reg + RAW'(1);
                end
            end
            bba_pkg::ST_SPLIT_RD: begin
                rd_addr  = dn_row;
                o_next   = o_dn;
                seg_next = seg_dn;
            end
            bba_pkg::ST_SPLIT_WR: begin
                wr_en   = 1'b1;
                wr_data = rd_data | (RB'(1) << (lo_cur ^ RL'(1)));
                cnt_op  = bba_pkg::CNT_INC;
            end
            bba_pkg::ST_FREE_RD: begin
                rd_addr = cur_row;
            end
            bba_pkg::ST_FREE_CHK: begin
                wr_en = 1'b1;
                if (buddy_free) begin
                    wr_data  = rd_data & ~(RB'(1) << (lo_cur ^ RL'(1)));
                    cnt_op   = bba_pkg::CNT_DEC;
                    seg_next = seg_reg >> 1;
                    o_next   = o_reg + OW'(1);
                end else begin
                    wr_data = rd_data | (RB'(1) << lo_cur);
                    cnt_op  = bba_pkg::CNT_INC;
                end
            end
            bba_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = fail_reg;
                    m_addr_next   = (fail_reg || mode_reg) ? '0 : (seg_reg << ord_reg);
                end
            end
            default: begin
                rd_addr = cur_row;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bba_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < ORDERS; i++) begin
                cnt_reg[i] <= (i == MAX_ORDER) ? bba_pkg::COUNT_W'(1) : '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            unique case (cnt_op)
                bba_pkg::CNT_INC: cnt_reg[cidx] <= cnt_reg[cidx] + bba_pkg::COUNT_W'(1);
                bba_pkg::CNT_DEC: cnt_reg[cidx] <= cnt_reg[cidx] - bba_pkg::COUNT_W'(1);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        ord_reg      <= ord_next;
        addr_reg     <= addr_next;
        o_reg        <= o_next;
        seg_reg      <= seg_next;
        k_reg        <= k_next;
        fail_reg     <= fail_next;
        m_addr_reg   <= m_addr_next;
        m_status_reg <= m_status_next;
    end

    assign s_ready           = (state_reg == bba_pkg::ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_granted_address = m_addr_reg;
    assign m_status          = m_status_reg;

endmodule

// ===== rtl/bba_map_store.sv =====
`timescale 1ns / 1ps
// bba_map_store: free bitmap rows, one write and one registered read per cycle
// per-row valid bits stand in for the reset contents; uses bba_pkg

module bba_map_store #(
    parameter int ROWS    = 37,
    parameter int RAW     = 6,
    parameter int TOP_ROW = 36
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [RAW-1:0]                rd_addr,
    output logic [bba_pkg::ROW_BITS-1:0]  rd_data,
    input  logic                          wr_en,
    input  logic [RAW-1:0]                wr_addr,
    input  logic [bba_pkg::ROW_BITS-1:0]  wr_data
);

    logic [bba_pkg::ROW_BITS-1:0] mem [ROWS];
    logic [ROWS-1:0]              vld_reg;
    logic [bba_pkg::ROW_BITS-1:0] q_reg;
    logic                         qv_reg;
    logic                         qt_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        q_reg  <= mem[rd_addr];
        qt_reg <= (rd_addr == RAW'(TOP_ROW));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            qv_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            qv_reg <= vld_reg[rd_addr];
        end
    end

    // unwritten rows read as reset contents: only the top block free
    assign rd_data = qv_reg ? q_reg
                   : (qt_reg ? bba_pkg::ROW_BITS'(1) : '0);

endmodule

// ===== rtl/bba_checker.sv =====
`timescale 1ns / 1ps
// bba_checker: port-level assertions for buddy_block_allocator
// depends on nothing; bound to the top level below

module bba_checker #(
    parameter int MAX_ORDER = 10
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [MAX_ORDER-1:0]         m_granted_address,
    input logic                         m_status
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous word still in work");

    a_fail_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_granted_address == '0)
        else $error("out of memory word with nonzero address");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted_address)
            && $stable(m_status))
        else $error("stalled result word changed");

endmodule

bind buddy_block_allocator bba_checker #(
    .MAX_ORDER (MAX_ORDER)
) u_bba_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_granted_address (m_granted_address),
    .m_status          (m_status)
);
